FILE: rtl/assert_macros.svh
// Assertion shorthands for RTL files that check themselves; only the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/pctm_pkg.sv
package pctm_pkg;

    localparam int MODE_W = 2;
    localparam int SYM_W  = 8;
    localparam int LEN_W  = 5;
    localparam int CODE_W = 24;
    localparam int ST_W   = 2;

    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_PREFIX = 2'd1;
    localparam logic [ST_W-1:0] ST_NONE   = 2'd2;

    // One table entry as it sits in the code memory.
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
    } pctm_entry_t;

    // Memory port controls from the sequencer.
    typedef struct packed {
        logic wr;
        logic rd;
    } pctm_mem_ctl_t;

    // A finished result item.
    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [SYM_W-1:0]  symbol_out;
        logic [LEN_W-1:0]  length_out;
        logic [CODE_W-1:0] bits_out;
        logic [LEN_W-1:0]  min_length;
        logic              table_ok;
    } pctm_res_t;

    // Ones in the low n bit positions of a code word.
    function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] n);
        logic [CODE_W-1:0] m;
        for (int k = 0; k < CODE_W; k++)
        begin
            m[k] = (LEN_W'(k) < n);
        end
        return m;
    endfunction

    // True when code a of length la begins code b of length lb.
    function automatic logic is_prefix(input logic [LEN_W-1:0] la,
                                       input logic [CODE_W-1:0] a,
                                       input logic [LEN_W-1:0] lb,
                                       input logic [CODE_W-1:0] b);
        return (la <= lb) && (((a ^ b) & code_mask(la)) == '0);
    endfunction

endpackage

FILE: rtl/pctm_store.sv
module pctm_store
    import pctm_pkg::*;
#(
    parameter int NUM_SYMBOLS = 256,
    localparam int AW = $clog2(NUM_SYMBOLS)
)
(
    input  logic          clk,
    input  pctm_mem_ctl_t ctl,
    input  logic [AW-1:0] addr,
    input  pctm_entry_t   wdata,
    output pctm_entry_t   rdata
);

    // Single-port code memory; read data is registered.
    pctm_entry_t mem [NUM_SYMBOLS];

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

FILE: rtl/pctm_seq.sv
module pctm_seq
    import pctm_pkg::*;
#(
    parameter int NUM_SYMBOLS   = 256,
    parameter int MAX_CODE_BITS = 24,
    localparam int AW = $clog2(NUM_SYMBOLS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_take,
    input  logic [MODE_W-1:0] mode,
    input  logic [SYM_W-1:0]  symbol,
    input  logic [LEN_W-1:0]  code_len,
    input  logic [CODE_W-1:0] code_bits,
    output logic              idle,
    output logic              res_valid,
    input  logic              res_take,
    output pctm_res_t         res,
    output pctm_mem_ctl_t     mem_ctl,
    output logic [AW-1:0]     mem_addr,
    output pctm_entry_t       mem_wdata,
    input  pctm_entry_t       mem_rdata
);

    localparam int SL_RAW = $clog2(MAX_CODE_BITS + 2);
    localparam int SL_W   = (SL_RAW > LEN_W) ? SL_RAW : LEN_W;
    localparam logic [SL_W-1:0]  SL_INIT   = SL_W'(MAX_CODE_BITS + 1);
    localparam logic [AW:0]      NUM_C     = (AW + 1)'(NUM_SYMBOLS);
    localparam logic [AW-1:0]    LAST_IDX  = AW'(NUM_SYMBOLS - 1);
    localparam logic [AW-1:0]    LAST_ROW  = AW'(NUM_SYMBOLS - 2);
    localparam logic [SYM_W:0]   SYM_LIMIT = (SYM_W + 1)'(NUM_SYMBOLS);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_WRITE     = 4'd1;
    localparam logic [3:0] S_READ      = 4'd2;
    localparam logic [3:0] S_READ_WAIT = 4'd3;
    localparam logic [3:0] S_LOOK      = 4'd4;
    localparam logic [3:0] S_ROW       = 4'd5;
    localparam logic [3:0] S_ROW_WAIT  = 4'd6;
    localparam logic [3:0] S_COL       = 4'd7;
    localparam logic [3:0] S_DONE      = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [SL_W-1:0]   sl_reg, sl_next;
    logic              vf_reg, vf_next;
    logic [AW:0]       idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pidx_reg, pidx_next;
    logic [AW-1:0]     row_reg, row_next;
    pctm_entry_t       erow_reg, erow_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic              symok_reg, symok_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CODE_W-1:0] bits_reg, bits_next;
    logic [ST_W-1:0]   st_reg, st_next;
    logic [SYM_W-1:0]  so_reg, so_next;
    logic [LEN_W-1:0]  lo_reg, lo_next;
    logic [CODE_W-1:0] bo_reg, bo_next;

    logic [LEN_W-1:0]  sat_len;
    logic              issue;
    logic              hit_match, hit_prefix, hit_pair;

    assign sat_len = (int'(code_len) > MAX_CODE_BITS) ? LEN_W'(MAX_CODE_BITS) : code_len;
    assign issue   = (idx_reg < NUM_C);

    assign hit_match  = (mem_rdata.len == len_reg) && (mem_rdata.bits == bits_reg);
    assign hit_prefix = is_prefix(len_reg, bits_reg, mem_rdata.len, mem_rdata.bits);
    assign hit_pair   = is_prefix(erow_reg.len, erow_reg.bits, mem_rdata.len, mem_rdata.bits)
                     || is_prefix(mem_rdata.len, mem_rdata.bits, erow_reg.len, erow_reg.bits);

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign mem_wdata = '{len: len_reg, bits: bits_reg};

    always_comb
    begin
        res.status     = st_reg;
        res.symbol_out = so_reg;
        res.length_out = lo_reg;
        res.bits_out   = bo_reg;
        res.min_length = sl_reg[LEN_W-1:0];
        res.table_ok   = vf_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        sl_next    = sl_reg;
        vf_next    = vf_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        pidx_next  = pidx_reg;
        row_next   = row_reg;
        erow_next  = erow_reg;
        sym_next   = sym_reg;
        symok_next = symok_reg;
        len_next   = len_reg;
        bits_next  = bits_reg;
        st_next    = st_reg;
        so_next    = so_reg;
        lo_next    = lo_reg;
        bo_next    = bo_reg;
        mem_ctl    = '0;
        mem_addr   = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (item_take)
                begin
                    sym_next   = symbol;
                    symok_next = ({1'b0, symbol} < SYM_LIMIT);
                    st_next    = ST_OK;
                    so_next    = '0;
                    lo_next    = '0;
                    bo_next    = '0;
                    idx_next   = '0;
                    row_next   = '0;
                    case (mode)
                        MODE_WRITE:
                        begin
                            len_next   = sat_len;
                            bits_next  = code_bits & code_mask(sat_len);
                            state_next = S_WRITE;
                        end
                        MODE_CHECK:
                        begin
                            state_next = S_ROW;
                        end
                        MODE_LOOKUP:
                        begin
                            len_next   = code_len;
                            bits_next  = code_bits & code_mask(code_len);
                            state_next = S_LOOK;
                        end
                        default:
                        begin
                            state_next = S_READ;
                        end
                    endcase
                end
            end
            S_WRITE:
            begin
                mem_addr = sym_reg[AW-1:0];
                if (symok_reg)
                begin
                    mem_ctl.wr = 1'b1;
                    if (SL_W'(len_reg) < sl_reg)
                    begin
                        sl_next = SL_W'(len_reg);
                    end
                end
                else
                begin
                    st_next = ST_NONE;
                end
                state_next = S_DONE;
            end
            S_READ:
            begin
                mem_addr = sym_reg[AW-1:0];
                if (symok_reg)
                begin
                    mem_ctl.rd = 1'b1;
                    state_next = S_READ_WAIT;
                end
                else
                begin
                    st_next    = ST_NONE;
                    state_next = S_DONE;
                end
            end
            S_READ_WAIT:
            begin
                lo_next    = mem_rdata.len;
                bo_next    = mem_rdata.bits;
                state_next = S_DONE;
            end
            S_LOOK:
            begin
                // Reads go out one per cycle; each compare sees its entry in the cycle after the read.
                if (issue)
                begin
                    mem_ctl.rd = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    pend_next  = 1'b1;
                    pidx_next  = idx_reg[AW-1:0];
                end
                if (pend_reg)
                begin
                    if (hit_match)
                    begin
                        st_next    = ST_OK;
                        so_next    = SYM_W'(pidx_reg);
                        state_next = S_DONE;
                    end
                    else if (hit_prefix)
                    begin
                        st_next    = ST_PREFIX;
                        state_next = S_DONE;
                    end
                    else if (pidx_reg == LAST_IDX)
                    begin
                        st_next    = ST_NONE;
                        state_next = S_DONE;
                    end
                end
            end
            S_ROW:
            begin
                mem_addr   = row_reg;
                mem_ctl.rd = 1'b1;
                state_next = S_ROW_WAIT;
            end
            S_ROW_WAIT:
            begin
                erow_next  = mem_rdata;
                idx_next   = {1'b0, row_reg} + 1'b1;
                state_next = S_COL;
            end
            S_COL:
            begin
                if (issue)
                begin
                    mem_ctl.rd = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    pend_next  = 1'b1;
                    pidx_next  = idx_reg[AW-1:0];
                end
                if (pend_reg)
                begin
                    if (hit_pair)
                    begin
                        vf_next    = 1'b0;
                        st_next    = ST_NONE;
                        state_next = S_DONE;
                    end
                    else if (pidx_reg == LAST_IDX)
                    begin
                        if (row_reg == LAST_ROW)
                        begin
                            vf_next    = 1'b1;
                            st_next    = ST_OK;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            row_next   = row_reg + 1'b1;
                            state_next = S_ROW;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sl_reg    <= SL_INIT;
            vf_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sl_reg    <= sl_next;
            vf_reg    <= vf_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        pidx_reg  <= pidx_next;
        row_reg   <= row_next;
        erow_reg  <= erow_next;
        sym_reg   <= sym_next;
        symok_reg <= symok_next;
        len_reg   <= len_next;
        bits_reg  <= bits_next;
        st_reg    <= st_next;
        so_reg    <= so_next;
        lo_reg    <= lo_next;
        bo_reg    <= bo_next;
    end

endmodule

FILE: rtl/prefix_code_table_match_top.sv
// Channel   Handshake             Beat fields
// input     in_valid / in_stall   mode, symbol, code_len, code_bits
// output    out_valid / out_stall status, symbol_out, length_out, bits_out,
//                                 min_length, table_ok
//
// One beat is worked at a time; every memory access goes through the single memory port.
// Lookup scans the entries in order and stops at the first entry that matches or that the code begins.
// Check reads each row entry, then scans the later entries against it, and stops at the first prefix pair.
// Reset is asynchronous and active low; the code memory is not cleared and must be written.
// A finished result sits in the output register while the next input beat is taken.
`include "assert_macros.svh"

module prefix_code_table_match_top
    import pctm_pkg::*;
#(
    parameter int NUM_SYMBOLS   = 256,
    parameter int MAX_CODE_BITS = 24
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [MODE_W-1:0] mode,
    input  logic [SYM_W-1:0]  symbol,
    input  logic [LEN_W-1:0]  code_len,
    input  logic [CODE_W-1:0] code_bits,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ST_W-1:0]   status,
    output logic [SYM_W-1:0]  symbol_out,
    output logic [LEN_W-1:0]  length_out,
    output logic [CODE_W-1:0] bits_out,
    output logic [LEN_W-1:0]  min_length,
    output logic              table_ok
);

    localparam int AW = $clog2(NUM_SYMBOLS);

    logic          seq_idle;
    logic          seq_res_valid;
    logic          slot_free;
    pctm_res_t     seq_res;
    pctm_mem_ctl_t mem_ctl;
    logic [AW-1:0] mem_addr;
    pctm_entry_t   mem_wdata;
    pctm_entry_t   mem_rdata;

    logic          out_valid_reg, out_valid_next;
    pctm_res_t     out_res_reg, out_res_next;

    // The sequencer takes a new beat only when it has nothing in progress.
    assign in_stall  = !seq_idle;
    // The output register frees up in the same cycle its beat is taken.
    assign slot_free = !out_valid_reg || !out_stall;

    pctm_seq #(
        .NUM_SYMBOLS   (NUM_SYMBOLS),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_take (in_valid && seq_idle),
        .mode      (mode),
        .symbol    (symbol),
        .code_len  (code_len),
        .code_bits (code_bits),
        .idle      (seq_idle),
        .res_valid (seq_res_valid),
        .res_take  (slot_free),
        .res       (seq_res),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    pctm_store #(
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_store (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (slot_free)
        begin
            out_valid_next = seq_res_valid;
            if (seq_res_valid)
            begin
                out_res_next = seq_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_res_reg.status;
    assign symbol_out = out_res_reg.symbol_out;
    assign length_out = out_res_reg.length_out;
    assign bits_out   = out_res_reg.bits_out;
    assign min_length = out_res_reg.min_length;
    assign table_ok   = out_res_reg.table_ok;

    // A taken beat always keeps the block busy for at least the next cycle.
    `ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)
    // Only an exact lookup match carries a symbol.
    `ASSERT_SAME(a_sym_only_on_match, clk, rst_n, out_valid && status != ST_OK,
                 symbol_out == '0)
    // A prefix answer comes from a lookup, which never returns stored code data.
    `ASSERT_SAME(a_prefix_no_data, clk, rst_n, out_valid && status == ST_PREFIX,
                 length_out == '0 && bits_out == '0)
    // Status never takes the unused code.
    `ASSERT_SAME(a_status_legal, clk, rst_n, out_valid,
                 status == ST_OK || status == ST_PREFIX || status == ST_NONE)

endmodule
